FILE: rtl/core/wssr_pkg.sv
package wssr_pkg;

   // Field widths
   localparam int unsigned SCORE_W  = 7;
   localparam int unsigned ID_W     = 8;
   localparam int unsigned KEY_W    = 11;
   localparam int unsigned WEIGHT_W = 4;
   localparam int unsigned RANK_W   = 4;

   // Configuration port
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = WEIGHT_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_A = 1'b0,
      CSR_WEIGHT_B = 1'b1
   } csr_idx_type;

   localparam logic [WEIGHT_W-1:0] WEIGHT_A_RESET = 4'd3;
   localparam logic [WEIGHT_W-1:0] WEIGHT_B_RESET = 4'd7;

   // Saturation value of the key
   localparam logic [KEY_W-1:0] KEY_MAX = '1;

   // One stored record
   typedef struct packed {
      logic [SCORE_W-1:0] score_a;
      logic [SCORE_W-1:0] score_b;
      logic [ID_W-1:0]    record_id;
      logic [KEY_W-1:0]   key;
   } rec_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // place the broadcast record in order
      logic advance;  // move every record one cell toward the head
   } cell_ctl_type;

endpackage

FILE: rtl/core/wssr_ifs.sv
interface wssr_req_if import wssr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score_a;
   logic [SCORE_W-1:0] score_b;
   logic [ID_W-1:0]    record_id;
   logic               last_in;

   modport source (output valid, score_a, score_b, record_id, last_in, input ready);
   modport sink   (input valid, score_a, score_b, record_id, last_in, output ready);
endinterface

interface wssr_rsp_if import wssr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANK_W-1:0]  rank;
   logic [SCORE_W-1:0] out_score_a;
   logic [SCORE_W-1:0] out_score_b;
   logic [ID_W-1:0]    out_id;
   logic [KEY_W-1:0]   weighted_key;
   logic               dropped;
   logic               last_out;

   modport source (output valid, rank, out_score_a, out_score_b, out_id, weighted_key,
                   dropped, last_out, input ready);
   modport sink   (input valid, rank, out_score_a, out_score_b, out_id, weighted_key,
                   dropped, last_out, output ready);
endinterface

FILE: rtl/core/wssr_key.sv
module wssr_key import wssr_pkg::*; (
   input  logic [WEIGHT_W-1:0] weight_a,
   input  logic [WEIGHT_W-1:0] weight_b,
   input  logic [SCORE_W-1:0]  score_a,
   input  logic [SCORE_W-1:0]  score_b,
   output logic [KEY_W-1:0]    key
);

   localparam int unsigned PROD_W = WEIGHT_W + SCORE_W;

   logic [PROD_W-1:0] prod_a;
   logic [PROD_W-1:0] prod_b;
   logic [PROD_W:0]   sum;

   // Two small products and their sum
   assign prod_a = PROD_W'(weight_a) * PROD_W'(score_a);
   assign prod_b = PROD_W'(weight_b) * PROD_W'(score_b);
   assign sum    = {1'b0, prod_a} + {1'b0, prod_b};

   // Saturate anything past the key width
   assign key = (sum[PROD_W:KEY_W] != '0) ? KEY_MAX : sum[KEY_W-1:0];

endmodule

FILE: rtl/core/wssr_cell.sv
module wssr_cell import wssr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  rec_type      new_rec,
   input  logic         prev_take,
   input  logic         prev_valid,
   input  rec_type      prev_rec,
   input  logic         next_valid,
   input  rec_type      next_rec,
   output logic         take,
   output logic         valid,
   output rec_type      rec
);

   logic    valid_ff;
   logic    valid_in;
   rec_type rec_ff;
   rec_type rec_in;

   // Empty cells and strictly smaller keys yield to the new record
   assign take = ctl.insert && (!valid_ff || (rec_ff.key < new_rec.key));

   // Next contents: shift down behind the insertion point, load at it,
   // or shift up toward the head while draining
   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (ctl.advance) begin
         valid_in = next_valid;
         rec_in   = next_rec;
      end else if (prev_take) begin
         valid_in = prev_valid;
         rec_in   = prev_rec;
      end else if (take) begin
         valid_in = 1'b1;
         rec_in   = new_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign valid = valid_ff;
   assign rec   = rec_ff;

endmodule

FILE: rtl/core/weighted_score_record_sort_core.sv
// Channel  Dir  Word                                             Handshake
// req_ch   in   score_a, score_b, record_id, last_in             valid/ready
// rsp_ch   out  rank, out_score_a, out_score_b, out_id,          valid/ready
//               weighted_key, dropped, last_out
// csr      in   csr_we, csr_index, csr_wdata                     write on csr_we
//
// Loading takes one record per cycle: the key is registered, then inserted
// into the cell chain by a broadcast compare in every cell.
// After the record marked last, input stalls and the chain drains from its
// head, one result per cycle while rsp_ch is ready, one per held record
// (1 to MAX_RECORDS); a new set may load while the final result waits.
// Synchronous reset empties the chain.
// A stalled rsp_ch holds its word and freezes the drain.
module weighted_score_record_sort_core import wssr_pkg::*; #(
   parameter int unsigned MAX_RECORDS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   wssr_req_if.sink              req_ch,
   wssr_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   // Configuration registers
   logic [WEIGHT_W-1:0] weight_a_ff;
   logic [WEIGHT_W-1:0] weight_b_ff;

   // Key stage
   logic                pend_valid_ff;
   logic                pend_last_ff;
   rec_type             pend_rec_ff;
   logic [KEY_W-1:0]    req_key;

   // Control and result registers
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    emit_idx_ff, emit_idx_in;
   logic                overflow_ff, overflow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rec_type             rsp_rec_ff, rsp_rec_in;
   logic [RANK_W-1:0]   rsp_rank_ff, rsp_rank_in;
   logic                rsp_dropped_ff, rsp_dropped_in;
   logic                rsp_last_ff, rsp_last_in;

   // Chain wiring
   cell_ctl_type                 ctl;
   logic [MAX_RECORDS-1:0]       cell_take;
   logic [MAX_RECORDS-1:0]       cell_valid;
   rec_type                      cell_rec [MAX_RECORDS];

   logic req_accept;
   logic has_room;
   logic load_rsp;
   logic emit_final;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_a_ff <= WEIGHT_A_RESET;
         weight_b_ff <= WEIGHT_B_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_WEIGHT_A: weight_a_ff <= csr_wdata;
            CSR_WEIGHT_B: weight_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Key computation ahead of the chain
   wssr_key u_key (
      .weight_a (weight_a_ff),
      .weight_b (weight_b_ff),
      .score_a  (req_ch.score_a),
      .score_b  (req_ch.score_b),
      .key      (req_key)
   );

   assign req_ch.ready = (state_ff == ST_LOAD) && !(pend_valid_ff && pend_last_ff);
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_last_ff          <= req_ch.last_in;
         pend_rec_ff.score_a   <= req_ch.score_a;
         pend_rec_ff.score_b   <= req_ch.score_b;
         pend_rec_ff.record_id <= req_ch.record_id;
         pend_rec_ff.key       <= req_key;
      end
   end

   // Chain commands
   assign has_room    = count_ff < CNT_W'(MAX_RECORDS);
   assign load_rsp    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign emit_final  = emit_idx_ff == CNT_W'(count_ff - CNT_W'(1));
   assign ctl.insert  = pend_valid_ff && has_room;
   assign ctl.advance = load_rsp;

   // Row of insertion cells, head at index 0
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      logic    prev_take_w;
      logic    prev_valid_w;
      rec_type prev_rec_w;
      logic    next_valid_w;
      rec_type next_rec_w;

      if (i == 0) begin : g_head
         assign prev_take_w  = 1'b0;
         assign prev_valid_w = 1'b0;
         assign prev_rec_w   = pend_rec_ff;
      end else begin : g_body
         assign prev_take_w  = cell_take[i-1];
         assign prev_valid_w = cell_valid[i-1];
         assign prev_rec_w   = cell_rec[i-1];
      end

      if (i == MAX_RECORDS - 1) begin : g_tail
         assign next_valid_w = 1'b0;
         assign next_rec_w   = pend_rec_ff;
      end else begin : g_mid
         assign next_valid_w = cell_valid[i+1];
         assign next_rec_w   = cell_rec[i+1];
      end

      wssr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_rec    (pend_rec_ff),
         .prev_take  (prev_take_w),
         .prev_valid (prev_valid_w),
         .prev_rec   (prev_rec_w),
         .next_valid (next_valid_w),
         .next_rec   (next_rec_w),
         .take       (cell_take[i]),
         .valid      (cell_valid[i]),
         .rec        (cell_rec[i])
      );
   end

   // Sequencer next state and result word
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      emit_idx_in    = emit_idx_ff;
      overflow_in    = overflow_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_rec_in     = rsp_rec_ff;
      rsp_rank_in    = rsp_rank_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_LOAD: begin
            if (pend_valid_ff) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (pend_last_ff) begin
                  state_in    = ST_EMIT;
                  emit_idx_in = '0;
               end
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               rsp_valid_in   = 1'b1;
               rsp_rec_in     = cell_rec[0];
               rsp_rank_in    = RANK_W'(emit_idx_ff);
               rsp_dropped_in = overflow_ff;
               rsp_last_in    = emit_final;
               emit_idx_in    = emit_idx_ff + CNT_W'(1);
               if (emit_final) begin
                  state_in    = ST_LOAD;
                  count_in    = '0;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         emit_idx_ff  <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         emit_idx_ff  <= emit_idx_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_rec_ff     <= rsp_rec_in;
      rsp_rank_ff    <= rsp_rank_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Result channel
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.rank         = rsp_rank_ff;
   assign rsp_ch.out_score_a  = rsp_rec_ff.score_a;
   assign rsp_ch.out_score_b  = rsp_rec_ff.score_b;
   assign rsp_ch.out_id       = rsp_rec_ff.record_id;
   assign rsp_ch.weighted_key = rsp_rec_ff.key;
   assign rsp_ch.dropped      = rsp_dropped_ff;
   assign rsp_ch.last_out     = rsp_last_ff;

`ifndef SYNTH
   // Occupancy never exceeds the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECORDS))
      else $error("record count beyond chain length");

   // The head cell holds a record whenever records are held while loading
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && count_ff != '0) |-> cell_valid[0])
      else $error("head cell empty while records are held");

   // No input is taken while the chain drains
   a_no_load_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !req_ch.ready)
      else $error("input accepted during drain");

   // The final result of a set returns the sequencer to loading
   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && emit_final) |=> (state_ff == ST_LOAD && rsp_ch.last_out))
      else $error("drain did not end on the final result");
`endif

endmodule
